@@ src/wcm_pkg.sv @@
// Shared types and constants for the window corner marker.
// Used by the front, queue, back, top level and checker; depends on nothing.
`timescale 1ns / 1ps

package wcm_pkg;

  // Image limits and field widths
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_WIDTH   = 4096;
  localparam int PIX_W       = 8;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int HGT_W       = 11;
  localparam int WID_W       = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  // Register reset values and fixed levels
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd100;
  localparam logic [PIX_W-1:0] PIX_WHITE    = 8'd255;
  localparam int               MIN_SIDE     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WIDTH  = 2'd2
  } cfg_idx_t;

  // One classified pixel, passed from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
    logic             bank;
  } desc_t;

endpackage

@@ src/wcm_front.sv @@
// Front end: configuration registers, pixel acceptance and position tracking.
// Classifies each pixel into a descriptor for the queue; depends on wcm_pkg.
`timescale 1ns / 1ps

module wcm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wcm_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [wcm_pkg::PIX_W-1:0]      thresh,
  input  logic                           q_full,
  output logic                           push,
  output wcm_pkg::desc_t                 push_desc
);
  import wcm_pkg::*;

  logic [PIX_W-1:0] thresh_r;
  logic [HGT_W-1:0] height_r;
  logic [WID_W-1:0] width_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             bank_r, bank_nxt;
  logic [HGT_W-1:0] h_eff;
  logic [WID_W-1:0] w_eff;
  logic             col_end;
  logic             img_end;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;
  assign thresh    = thresh_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      height_r <= HGT_W'(MAX_HEIGHT);
      width_r  <= WID_W'(MAX_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESH: thresh_r <= cfg_data[PIX_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the image size to the supported range.
  always_comb begin
    if (height_r < HGT_W'(MIN_SIDE)) begin
      h_eff = HGT_W'(MIN_SIDE);
    end else if (height_r > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    if (width_r < WID_W'(MIN_SIDE)) begin
      w_eff = WID_W'(MIN_SIDE);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
  end

  // Column and image boundaries of the current pixel
  assign col_end = HGT_W'(row_r) >= (h_eff - HGT_W'(1));
  assign img_end = col_end && (WID_W'(col_r) >= (w_eff - WID_W'(1)));

  // A transaction is taken whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_desc.pixel = in_pixel;
    push_desc.row   = row_r;
    push_desc.col   = col_r;
    push_desc.emit  = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    push_desc.last  = img_end;
    push_desc.bank  = bank_r;
  end

  // Scan position for the next pixel
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    bank_nxt = bank_r;
    if (push) begin
      if (col_end) begin
        row_nxt  = '0;
        bank_nxt = ~bank_r;
        col_nxt  = img_end ? '0 : col_r + COL_W'(1);
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

@@ src/wcm_queue.sv @@
// Short descriptor queue between the front and the back end.
// Flip-flop storage with a fill count; depends on wcm_pkg.
`timescale 1ns / 1ps

module wcm_queue #(
  parameter int Q_DEPTH = wcm_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wcm_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output wcm_pkg::desc_t q_desc
);
  import wcm_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  desc_t            slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = count_r == CNT_W'(Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_desc  = slot_r[rptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/wcm_back.sv @@
// Back end: two column banks, the corner test and the output register.
// Consumes descriptors from the queue; depends on wcm_pkg.
`timescale 1ns / 1ps

module wcm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  wcm_pkg::desc_t            q_desc,
  output logic                      pop,
  input  logic [wcm_pkg::PIX_W-1:0] thresh,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [wcm_pkg::ROW_W-1:0] out_center_row,
  output logic [wcm_pkg::COL_W-1:0] out_center_col,
  output logic                      out_is_corner,
  output logic [wcm_pkg::PIX_W-1:0] out_pixel_out,
  output logic                      out_last_of_image
);
  import wcm_pkg::*;

  function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Column banks: the older bank holds column x-2, the other column x-1.
  logic [PIX_W-1:0] bank0 [MAX_HEIGHT];
  logic [PIX_W-1:0] bank1 [MAX_HEIGHT];
  logic [PIX_W-1:0] rd0_r, rd1_r;

  desc_t            e_desc_r;
  logic             e_valid_r;
  logic [PIX_W-1:0] a_d1_r, a_d2_r, b_d1_r, p1_r, p2_r;

  logic             out_valid_r, is_corner_r, last_r;
  logic [ROW_W-1:0] ctr_row_r;
  logic [COL_W-1:0] ctr_col_r;
  logic [PIX_W-1:0] pix_out_r;

  logic             out_free, e_adv;
  logic [PIX_W-1:0] a_rd, b_rd, tl, tr, bl, br;
  logic [PIX_W-1:0] top, bot;
  logic             sides, top_ok, bot_ok, mark;
  logic             we0, we1;
  logic [ROW_W-1:0] wa0, wa1;
  logic [PIX_W-1:0] wd0, wd1;

  // Handshake between the queue, the evaluation stage and the output register
  assign out_free = !out_valid_r || !out_stall;
  assign e_adv    = e_valid_r && (!e_desc_r.emit || out_free);
  assign pop      = q_valid && (!e_valid_r || e_adv);

  // Route bank reads to their roles.
  assign a_rd = e_desc_r.bank ? rd1_r : rd0_r;
  assign b_rd = e_desc_r.bank ? rd0_r : rd1_r;

  // Window corners of the center one row up and one column left
  assign tl = a_d2_r;
  assign bl = a_rd;
  assign tr = p2_r;
  assign br = e_desc_r.pixel;

  // Corner test: a top or bottom edge, confirmed by a side edge
  always_comb begin
    top    = absd(tl, tr);
    bot    = absd(bl, br);
    sides  = (absd(tl, bl) > thresh) || (absd(tr, br) > thresh);
    top_ok = (top > thresh) && (top != PIX_WHITE);
    bot_ok = (bot > thresh) && (bot != PIX_WHITE);
    mark   = e_desc_r.emit && (top_ok || bot_ok) && sides;
  end

  // Bank writes: the current pixel into the older bank, a mark into the other.
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = e_desc_r.row;
    wa1 = e_desc_r.row;
    wd0 = e_desc_r.pixel;
    wd1 = e_desc_r.pixel;
    if (e_desc_r.bank) begin
      we1 = e_adv;
      we0 = e_adv && mark;
      wa0 = e_desc_r.row - ROW_W'(1);
      wd0 = PIX_WHITE;
    end else begin
      we0 = e_adv;
      we1 = e_adv && mark;
      wa1 = e_desc_r.row - ROW_W'(1);
      wd1 = PIX_WHITE;
    end
  end

  // Bank storage with registered read data
  always_ff @(posedge clk) begin
    if (pop) begin
      rd0_r <= bank0[q_desc.row];
    end
    if (we0) begin
      bank0[wa0] <= wd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd1_r <= bank1[q_desc.row];
    end
    if (we1) begin
      bank1[wa1] <= wd1;
    end
  end

  // Evaluation stage and the short history of the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (pop) begin
      e_valid_r <= 1'b1;
    end else if (e_adv) begin
      e_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e_desc_r <= q_desc;
    end
    if (e_adv) begin
      a_d1_r <= a_rd;
      a_d2_r <= a_d1_r;
      b_d1_r <= b_rd;
      p1_r   <= e_desc_r.pixel;
      p2_r   <= p1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_adv && e_desc_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv && e_desc_r.emit) begin
      ctr_row_r   <= e_desc_r.row - ROW_W'(1);
      ctr_col_r   <= e_desc_r.col - COL_W'(1);
      is_corner_r <= mark;
      pix_out_r   <= mark ? PIX_WHITE : b_d1_r;
      last_r      <= e_desc_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_center_row    = ctr_row_r;
  assign out_center_col    = ctr_col_r;
  assign out_is_corner     = is_corner_r;
  assign out_pixel_out     = pix_out_r;
  assign out_last_of_image = last_r;

endmodule

@@ src/window_corner_marker.sv @@
// Top level of the window corner marker: front end, descriptor queue, back end.
// Depends on wcm_pkg, wcm_front, wcm_queue and wcm_back.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    in_pixel
//   out      out_valid / out_stall  out_center_row, out_center_col, out_is_corner,
//                                   out_pixel_out, out_last_of_image
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock is taken and one result per interior center is given,
// sustained while out_stall is low; per pixel each column bank is read once and
// written at most once. A result is registered after the queue and evaluation stage.
// Reset is synchronous on rst_n; the column banks are not cleared and need none.
// in_stall rises only when the descriptor queue is full; a stalled result holds
// in the output register while further pixels keep filling the queue.
`timescale 1ns / 1ps

module window_corner_marker #(
  parameter int Q_DEPTH = wcm_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wcm_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wcm_pkg::ROW_W-1:0]      out_center_row,
  output logic [wcm_pkg::COL_W-1:0]      out_center_col,
  output logic                           out_is_corner,
  output logic [wcm_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last_of_image,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wcm_pkg::*;

  logic             push, q_full, pop, q_valid;
  desc_t            push_desc, q_desc;
  logic [PIX_W-1:0] thresh;

  // Acceptance, configuration and classification
  wcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thresh    (thresh),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // Decoupling queue
  wcm_queue #(
    .Q_DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  // Window evaluation and results
  wcm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_desc            (q_desc),
    .pop               (pop),
    .thresh            (thresh),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_center_row    (out_center_row),
    .out_center_col    (out_center_col),
    .out_is_corner     (out_is_corner),
    .out_pixel_out     (out_pixel_out),
    .out_last_of_image (out_last_of_image)
  );

endmodule

@@ src/wcm_checker.sv @@
// Port-level checks for the window corner marker, bound to the top level.
// Depends on wcm_pkg and window_corner_marker.
`timescale 1ns / 1ps

module wcm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [wcm_pkg::ROW_W-1:0] out_center_row,
  input logic [wcm_pkg::COL_W-1:0] out_center_col,
  input logic                      out_is_corner,
  input logic [wcm_pkg::PIX_W-1:0] out_pixel_out,
  input logic                      out_last_of_image
);
  import wcm_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_row) &&
      $stable(out_center_col) && $stable(out_is_corner) &&
      $stable(out_pixel_out) && $stable(out_last_of_image))
    else $error("stalled result changed");

  // A marked center always reads back as white.
  a_mark_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_corner |-> out_pixel_out == PIX_WHITE)
    else $error("marked center is not white");

  // Border rows and columns never produce a result.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_row != '0 && out_center_col != '0)
    else $error("result for a border center");

endmodule

bind window_corner_marker wcm_checker u_wcm_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for window_corner_marker: streams column-major images,
// predicts every interior center decision and compares each result transaction.
// Depends on wcm_pkg and the window_corner_marker RTL.
`timescale 1ns / 1ps

module tb_top;
  import wcm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 280;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT     = 25;
  localparam int STALL_PCT    = 33;

  // Register index past the end of the register list; the block ignores it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One center decision as the result channel reports it.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             corner;
    logic [PIX_W-1:0] level;
    logic             last;
  } centre_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_W-1:0]      out_center_row;
  logic [COL_W-1:0]      out_center_col;
  logic                  out_is_corner;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_last_of_image;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  window_corner_marker dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shared control of the two sides.
  logic gaps_on = 1'b1;
  logic rx_quiet = 1'b0;
  int   hold_token = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   n_errors = 0;
  int   pixels_sent = 0;
  int   cycle_cnt = 0;

  // Predictor state: configuration, the two column banks, position and delay line.
  logic [PIX_W-1:0] thr;
  logic [HGT_W-1:0] hgt;
  logic [WID_W-1:0] wid;
  logic [PIX_W-1:0] col_mem [0:2*MAX_HEIGHT-1];
  int unsigned      row_cnt;
  int unsigned      col_cnt;
  bit               bank_sel;
  logic [PIX_W-1:0] px_d1;
  logic [PIX_W-1:0] px_d2;
  centre_t          pending_centres [$];

  function automatic logic [PIX_W-1:0] abs_gap(input logic [PIX_W-1:0] a, b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned side_limit(input int unsigned v, hi);
    if (v < MIN_SIDE) return MIN_SIDE;
    return (v > hi) ? hi : v;
  endfunction

  // The top pair decides first; the bottom pair is tried only when the top one fails.
  function automatic bit window_marks(input logic [PIX_W-1:0] tl, tr, bl, br);
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] bot;
    bit               sides;
    top = abs_gap(tl, tr);
    bot = abs_gap(bl, br);
    sides = (abs_gap(tl, bl) > thr) || (abs_gap(tr, br) > thr);
    if (top > thr && top < PIX_WHITE) return sides;
    if (bot > thr && bot < PIX_WHITE) return sides;
    return 1'b0;
  endfunction

  // Advances the image position by one pixel and queues the center it decides, if any.
  function automatic void advance_window(input logic [PIX_W-1:0] px);
    int unsigned      h;
    int unsigned      w;
    int unsigned      oldb;
    int unsigned      midb;
    bit               col_end;
    bit               img_end;
    bit               mark;
    logic [PIX_W-1:0] ctr;
    centre_t          res;
    h = side_limit(hgt, MAX_HEIGHT);
    w = side_limit(wid, MAX_WIDTH);
    oldb = bank_sel ? MAX_HEIGHT : 0;
    midb = bank_sel ? 0 : MAX_HEIGHT;
    col_end = (row_cnt >= h - 1);
    img_end = col_end && (col_cnt >= w - 1);
    if (row_cnt >= 2 && col_cnt >= 2) begin
      ctr = col_mem[midb + row_cnt - 1];
      mark = window_marks(col_mem[oldb + row_cnt - 2], px_d2, col_mem[oldb + row_cnt], px);
      // A marked center is written back, so later windows see it as white.
      if (mark) begin
        col_mem[midb + row_cnt - 1] = PIX_WHITE;
        ctr = PIX_WHITE;
      end
      res.row    = ROW_W'(row_cnt - 1);
      res.col    = COL_W'(col_cnt - 1);
      res.corner = mark;
      res.level  = ctr;
      res.last   = img_end;
      pending_centres.push_back(res);
    end
    // The current column lands in the old bank two rows late.
    if (row_cnt >= 2) col_mem[oldb + row_cnt - 2] = px_d2;
    if (col_end) begin
      if (row_cnt >= 1) col_mem[oldb + row_cnt - 1] = px_d1;
      col_mem[oldb + row_cnt] = px;
    end
    px_d2 = px_d1;
    px_d1 = px;
    if (col_end) begin
      row_cnt = 0;
      bank_sel = !bank_sel;
      col_cnt = img_end ? 0 : col_cnt + 1;
    end else begin
      row_cnt++;
    end
  endfunction

  // Pixel mix with many black and white values so that full-scale differences occur.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return PIX_WHITE;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Sends one pixel transaction, with an occasional gap before it.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    advance_window(px);
  endtask

  // Writes one register and mirrors it into the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESH: thr = PIX_W'(value);
      CFG_HEIGHT: hgt = HGT_W'(value);
      CFG_WIDTH:  wid = WID_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stops the sender, lets the receiver run freely until every expected
  // result has come, then gives the pipeline time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    rx_quiet <= 1'b1;
    @(posedge clk);
    while (pending_centres.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    rx_quiet <= 1'b0;
  endtask

  // Sends random pixels until the predictor is back at the start of an image.
  task automatic stream_image();
    do send_pixel(pick_pixel());
    while (row_cnt != 0 || col_cnt != 0);
  endtask

  // Reset threshold and width with a height below the minimum; after a few
  // columns a small width closes the image.
  task automatic test_widest_image();
    wait_idle();
    write_reg(CFG_HEIGHT, 0);
    repeat (15) send_pixel(pick_pixel());
    wait_idle();
    write_reg(CFG_WIDTH, 3);
    stream_image();
  endtask

  // Tall, narrow image with a zero threshold.
  task automatic test_zero_threshold();
    wait_idle();
    write_reg(CFG_THRESH, 0);
    write_reg(CFG_HEIGHT, 24);
    write_reg(CFG_WIDTH, 3);
    stream_image();
  endtask

  // Hand-built 5x5 image: top-pair mark, a full-scale top pair that falls
  // through to the bottom pair, unmarked windows, and marks read back later.
  task automatic test_directed_window();
    logic [PIX_W-1:0] pat [25];
    pat = '{8'd0,   8'd30,  8'd100, 8'd0,   8'd255,
            8'd0,   8'd120, 8'd10,  8'd255, 8'd0,
            8'd200, 8'd60,  8'd90,  8'd255, 8'd0,
            8'd255, 8'd200, 8'd200, 8'd0,   8'd255,
            8'd200, 8'd5,   8'd100, 8'd255, 8'd0};
    wait_idle();
    write_reg(CFG_THRESH, 50);
    write_reg(CFG_HEIGHT, 5);
    write_reg(CFG_WIDTH, 5);
    foreach (pat[i]) send_pixel(pat[i]);
  endtask

  // Out-of-range sizes saturate; the threshold at its top never marks.
  // The oversized width runs a few columns before a small width closes the image.
  task automatic test_size_saturation();
    wait_idle();
    write_reg(CFG_THRESH, 255);
    write_reg(CFG_HEIGHT, 2);
    write_reg(CFG_WIDTH, 8191);
    repeat (12) send_pixel(pick_pixel());
    wait_idle();
    write_reg(CFG_WIDTH, 3);
    stream_image();
    wait_idle();
    write_reg(CFG_THRESH, $urandom_range(255));
    write_reg(CFG_HEIGHT, 1);
    write_reg(CFG_WIDTH, 0);
    stream_image();
  endtask

  // Threshold and width changes in the middle of an image.
  task automatic test_midimage_writes();
    wait_idle();
    write_reg(CFG_THRESH, 60);
    write_reg(CFG_HEIGHT, 6);
    write_reg(CFG_WIDTH, 8);
    repeat (15) send_pixel(pick_pixel());
    wait_idle();
    write_reg(CFG_THRESH, $urandom_range(255));
    repeat (10) send_pixel(pick_pixel());
    wait_idle();
    // A width below the current column ends the image at this column.
    write_reg(CFG_WIDTH, 3);
    stream_image();
    wait_idle();
    write_reg(CFG_HEIGHT, 4);
    write_reg(CFG_WIDTH, 4);
    repeat (9) send_pixel(pick_pixel());
    wait_idle();
    // A larger width extends the image being scanned.
    write_reg(CFG_WIDTH, 6);
    stream_image();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_long_hold();
    wait_idle();
    write_reg(CFG_THRESH, $urandom_range(20, 120));
    write_reg(CFG_HEIGHT, 16);
    write_reg(CFG_WIDTH, 8);
    gaps_on <= 1'b0;
    hold_token <= hold_token + 1;
    stream_image();
    gaps_on <= 1'b1;
  endtask

  // Small random images with random settings; a stretch in the middle runs without gaps.
  task automatic test_random_images();
    int base;
    int done;
    base = pixels_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      wait_idle();
      gaps_on <= (done < 80) || (done > 200);
      case ($urandom_range(7))
        0: write_reg(CFG_THRESH, 0);
        1: write_reg(CFG_THRESH, 255);
        default: write_reg(CFG_THRESH, $urandom_range(255));
      endcase
      case ($urandom_range(9))
        0: write_reg(CFG_HEIGHT, $urandom_range(2));
        1: write_reg(CFG_HEIGHT, $urandom_range(9, 24));
        default: write_reg(CFG_HEIGHT, $urandom_range(3, 8));
      endcase
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom_range(8191));
      write_reg(CFG_WIDTH, $urandom_range(3, 8));
      stream_image();
      done = pixels_sent - base;
    end
    gaps_on <= 1'b1;
  endtask

  // Stall: a counted long hold when asked, off when draining or gap-free, else random.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_quiet || !gaps_on) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < STALL_PCT);
    end
  end

  function automatic void compare_field(input string name, input logic [COL_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Each accepted result transaction is matched against the oldest expected center.
  always @(posedge clk) begin : check_results
    centre_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_centres.size() == 0) begin
        $error("unexpected result: row %0d col %0d", out_center_row, out_center_col);
        n_errors++;
      end else begin
        want = pending_centres.pop_front();
        compare_field("center_row", COL_W'(want.row), COL_W'(out_center_row));
        compare_field("center_col", want.col, out_center_col);
        compare_field("is_corner", COL_W'(want.corner), COL_W'(out_is_corner));
        compare_field("pixel_out", COL_W'(want.level), COL_W'(out_pixel_out));
        compare_field("last_of_image", COL_W'(want.last), COL_W'(out_last_of_image));
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence: reset, then each test in turn, then the verdict.
  initial begin
    thr = THRESH_RESET;
    hgt = HGT_W'(MAX_HEIGHT);
    wid = WID_W'(MAX_WIDTH);
    row_cnt = 0;
    col_cnt = 0;
    bank_sel = 1'b0;
    px_d1 = '0;
    px_d2 = '0;
    foreach (col_mem[i]) col_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_widest_image();
    test_zero_threshold();
    test_directed_window();
    test_size_saturation();
    test_midimage_writes();
    test_long_hold();
    test_random_images();
    wait_idle();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
